### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the C-SCAN scheduler.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define CSDS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition in one cycle implies another in the same cycle.
`define CSDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  `CSDS_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

### rtl/csds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csds_pkg
// Beat types, register codes and sequencer states of the C-SCAN scheduler.
// ----------------------------------------------------------------------------
package csds_pkg;

  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned TOTAL_W   = 18;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_END_TRACK      = 1'b1;

  localparam logic [FIELD_W-1:0] START_POSITION_RESET = 16'd0;
  localparam logic [FIELD_W-1:0] END_TRACK_RESET      = 16'd200;

  typedef struct packed {
    logic [FIELD_W-1:0] request_track;
    logic               last_request;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] served_track;
    logic [FIELD_W-1:0] seek_distance;
    logic [TOTAL_W-1:0] total_movement;
    logic               is_summary;
    logic               overflow;
    logic               last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SHIFT,
    ST_PLACE,
    ST_START,
    ST_SCAN,
    ST_EVAL,
    ST_WRAP,
    ST_SUM
  } seq_state_t;

endpackage

### rtl/csds_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csds_store
// Request store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module csds_store #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/csds_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csds_seq
// Sorted-insert loader and two-pass C-SCAN sweep over the request store.
// ----------------------------------------------------------------------------
module csds_seq #(
  parameter int unsigned MAX_PENDING = 32,
  parameter int unsigned TRACK_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  csds_pkg::in_item_t          in_data,
  output logic                        in_ready,
  input  logic [csds_pkg::FIELD_W-1:0] start_position,
  input  logic [csds_pkg::FIELD_W-1:0] end_track,
  input  logic                        slot_free,
  output logic                        res_push,
  output csds_pkg::out_item_t         res_data
);

  localparam int unsigned TW    = TRACK_BITS;
  localparam int unsigned IW    = $clog2(MAX_PENDING);
  localparam int unsigned CW    = $clog2(MAX_PENDING + 1);
  localparam int unsigned EXT_W = (TW > csds_pkg::FIELD_W) ? TW : csds_pkg::FIELD_W;
  localparam int unsigned SUM_W = ((TW > csds_pkg::TOTAL_W) ? TW : csds_pkg::TOTAL_W) + 2;

  csds_pkg::seq_state_t state_r, state_nxt;

  logic [CW-1:0]                count_r, count_nxt;
  logic                         dropped_r, dropped_nxt;
  logic                         last_r, last_nxt;
  logic [TW-1:0]                v_r, v_nxt;
  logic [IW-1:0]                j_r, j_nxt;
  logic [IW-1:0]                i_r, i_nxt;
  logic                         pass_r, pass_nxt;
  logic [TW-1:0]                head_r, head_nxt;
  logic [TW-1:0]                start_r, start_nxt;
  logic [csds_pkg::TOTAL_W-1:0] total_r, total_nxt;

  logic [EXT_W-1:0] in_ext, end_ext, start_ext, rd_ext, dist_ext;
  logic [TW-1:0]    trk_in, end_t, trk_clamp, start_t, start_clamp;
  logic [TW-1:0]    rd_data, seek_dist;
  logic             accept, count_full, rd_gt, i_last, serve_hit;
  logic [SUM_W-1:0] add_sum, wrap_sum;
  logic [csds_pkg::TOTAL_W-1:0] add_sat, wrap_sat;

  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [TW-1:0] mem_wdata;

  csds_store #(
    .DEPTH (MAX_PENDING),
    .WIDTH (TW),
    .AW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (rd_data)
  );

  // Track fields narrow or widen to the internal track width.
  assign in_ext      = EXT_W'(in_data.request_track);
  assign end_ext     = EXT_W'(end_track);
  assign start_ext   = EXT_W'(start_position);
  assign trk_in      = in_ext[TW-1:0];
  assign end_t       = end_ext[TW-1:0];
  assign start_t     = start_ext[TW-1:0];
  assign trk_clamp   = (trk_in > end_t) ? end_t : trk_in;
  assign start_clamp = (start_t > end_t) ? end_t : start_t;

  assign accept     = in_valid && in_ready;
  assign count_full = (count_r == CW'(MAX_PENDING));
  assign rd_gt      = (rd_data > v_r);
  assign i_last     = ((CW'(i_r) + CW'(1)) == count_r);
  assign serve_hit  = pass_r ? (rd_data < start_r) : (rd_data >= start_r);

  // Both passes move upward, so the seek is a plain difference.
  assign seek_dist = rd_data - head_r;
  assign rd_ext    = EXT_W'(rd_data);
  assign dist_ext  = EXT_W'(seek_dist);
  assign add_sum   = SUM_W'(total_r) + SUM_W'(seek_dist);
  assign wrap_sum  = SUM_W'(total_r) + SUM_W'(end_t - head_r) + SUM_W'(end_t);
  assign add_sat   = (add_sum > SUM_W'(csds_pkg::TOTAL_MAX)) ?
                     csds_pkg::TOTAL_MAX : add_sum[csds_pkg::TOTAL_W-1:0];
  assign wrap_sat  = (wrap_sum > SUM_W'(csds_pkg::TOTAL_MAX)) ?
                     csds_pkg::TOTAL_MAX : wrap_sum[csds_pkg::TOTAL_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      csds_pkg::ST_LOAD: begin
        if (accept) begin
          if (!count_full && (count_r != '0)) begin
            state_nxt = csds_pkg::ST_SHIFT;
          end else if (in_data.last_request) begin
            state_nxt = csds_pkg::ST_START;
          end
        end
      end
      csds_pkg::ST_SHIFT: begin
        if (rd_gt) begin
          if (j_r == IW'(1)) begin
            state_nxt = csds_pkg::ST_PLACE;
          end
        end else begin
          state_nxt = last_r ? csds_pkg::ST_START : csds_pkg::ST_LOAD;
        end
      end
      csds_pkg::ST_PLACE: begin
        state_nxt = last_r ? csds_pkg::ST_START : csds_pkg::ST_LOAD;
      end
      csds_pkg::ST_START: begin
        state_nxt = (count_r == '0) ? csds_pkg::ST_WRAP : csds_pkg::ST_SCAN;
      end
      csds_pkg::ST_SCAN: begin
        state_nxt = csds_pkg::ST_EVAL;
      end
      csds_pkg::ST_EVAL: begin
        if (pass_r && !serve_hit) begin
          state_nxt = csds_pkg::ST_SUM;
        end else if (serve_hit && !slot_free) begin
          state_nxt = csds_pkg::ST_EVAL;
        end else if (i_last) begin
          state_nxt = pass_r ? csds_pkg::ST_SUM : csds_pkg::ST_WRAP;
        end else begin
          state_nxt = csds_pkg::ST_SCAN;
        end
      end
      csds_pkg::ST_WRAP: begin
        state_nxt = (count_r == '0) ? csds_pkg::ST_SUM : csds_pkg::ST_SCAN;
      end
      csds_pkg::ST_SUM: begin
        if (slot_free) begin
          state_nxt = csds_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = csds_pkg::ST_LOAD;
      end
    endcase
  end

  // Outputs: store port, input ready, result beat
  always_comb begin
    in_ready  = (state_r == csds_pkg::ST_LOAD);
    mem_we    = 1'b0;
    mem_waddr = j_r;
    mem_wdata = v_r;
    mem_re    = 1'b0;
    mem_raddr = i_r;
    res_push  = 1'b0;
    res_data  = '0;
    case (state_r)
      csds_pkg::ST_LOAD: begin
        if (accept && !count_full) begin
          if (count_r == '0) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = trk_clamp;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = count_r[IW-1:0] - IW'(1);
          end
        end
      end
      csds_pkg::ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = rd_gt ? rd_data : v_r;
        if (rd_gt && (j_r != IW'(1))) begin
          mem_re    = 1'b1;
          mem_raddr = j_r - IW'(2);
        end
      end
      csds_pkg::ST_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = v_r;
      end
      csds_pkg::ST_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = i_r;
      end
      csds_pkg::ST_EVAL: begin
        if (serve_hit && slot_free) begin
          res_push                = 1'b1;
          res_data.served_track   = rd_ext[csds_pkg::FIELD_W-1:0];
          res_data.seek_distance  = dist_ext[csds_pkg::FIELD_W-1:0];
          res_data.total_movement = add_sat;
          res_data.overflow       = dropped_r;
        end
      end
      csds_pkg::ST_SUM: begin
        if (slot_free) begin
          res_push                = 1'b1;
          res_data.total_movement = total_r;
          res_data.is_summary     = 1'b1;
          res_data.overflow       = dropped_r;
          res_data.last_result    = 1'b1;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Datapath next values
  always_comb begin
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    last_nxt    = last_r;
    v_nxt       = v_r;
    j_nxt       = j_r;
    i_nxt       = i_r;
    pass_nxt    = pass_r;
    head_nxt    = head_r;
    start_nxt   = start_r;
    total_nxt   = total_r;
    case (state_r)
      csds_pkg::ST_LOAD: begin
        if (accept) begin
          last_nxt = in_data.last_request;
          if (!count_full) begin
            v_nxt     = trk_clamp;
            j_nxt     = count_r[IW-1:0];
            count_nxt = count_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
        end
      end
      csds_pkg::ST_SHIFT: begin
        if (rd_gt) begin
          j_nxt = j_r - IW'(1);
        end
      end
      csds_pkg::ST_START: begin
        start_nxt = start_clamp;
        head_nxt  = start_clamp;
        total_nxt = '0;
        i_nxt     = '0;
        pass_nxt  = 1'b0;
      end
      csds_pkg::ST_EVAL: begin
        if (serve_hit && slot_free) begin
          total_nxt = add_sat;
          head_nxt  = rd_data;
          i_nxt     = i_r + IW'(1);
        end else if (!serve_hit && !pass_r) begin
          i_nxt = i_r + IW'(1);
        end
      end
      csds_pkg::ST_WRAP: begin
        total_nxt = wrap_sat;
        head_nxt  = '0;
        i_nxt     = '0;
        pass_nxt  = 1'b1;
      end
      csds_pkg::ST_SUM: begin
        if (slot_free) begin
          count_nxt   = '0;
          dropped_nxt = 1'b0;
          total_nxt   = '0;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= csds_pkg::ST_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
      last_r    <= 1'b0;
      pass_r    <= 1'b0;
      head_r    <= '0;
      total_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      last_r    <= last_nxt;
      pass_r    <= pass_nxt;
      head_r    <= head_nxt;
      total_r   <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    j_r     <= j_nxt;
    i_r     <= i_nxt;
    start_r <= start_nxt;
  end

endmodule

### rtl/cscan_disk_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscan_disk_scheduler
// C-SCAN disk request scheduler: loads a batch of tracks, serves them upward
// from the start position, wraps to track zero and serves the rest.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake              Beat
//   in_      in   in_valid / in_ready    request_track, last_request
//   out_     out  out_valid / out_ready  served_track .. last_result
//   cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data (16-bit register)
//
// Loading: each request beat is inserted in sorted position in the request
// store. The first request of a batch is written at once, a dropped one is
// discarded; any other reads the last stored entry, each larger entry then
// moves up one place (SHIFT) and the request lands in the gap, in PLACE if it
// is the smallest; the store's single read port with registered read data sets this order.
// Serving: a set-up state, then a read (SCAN) and an evaluate (EVAL) per
// stored entry examined, a wrap state and a summary state; the lower pass
// stops at the first track at or above the start.
// Reset (rst_n low, synchronous) clears the batch; the store needs no clear.
// Result beats wait in one output register; a stalled out_ready holds the
// sweep, and the next batch's requests are taken while the summary beat waits there.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cscan_disk_scheduler #(
  parameter int unsigned MAX_PENDING = 32,
  parameter int unsigned TRACK_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  csds_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output csds_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [csds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csds_pkg::FIELD_W-1:0]  cfg_data
);

  logic [csds_pkg::FIELD_W-1:0] start_position_r, start_position_nxt;
  logic [csds_pkg::FIELD_W-1:0] end_track_r, end_track_nxt;
  logic                         out_valid_r, out_valid_nxt;
  csds_pkg::out_item_t          out_data_r, out_data_nxt;

  logic                slot_free;
  logic                res_push;
  csds_pkg::out_item_t res_data;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  always_comb begin
    start_position_nxt = start_position_r;
    end_track_nxt      = end_track_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        csds_pkg::REG_START_POSITION: start_position_nxt = cfg_data;
        csds_pkg::REG_END_TRACK:      end_track_nxt      = cfg_data;
        default:                      end_track_nxt      = end_track_r;
      endcase
    end
  end

  // The output register is free when empty or being drained this cycle.
  assign slot_free = !out_valid_r || out_ready;

  csds_seq #(
    .MAX_PENDING (MAX_PENDING),
    .TRACK_BITS  (TRACK_BITS)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_data        (in_data),
    .in_ready       (in_ready),
    .start_position (start_position_r),
    .end_track      (end_track_r),
    .slot_free      (slot_free),
    .res_push       (res_push),
    .res_data       (res_data)
  );

  // Load a new beat on push, drop the valid once the beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_position_r <= csds_pkg::START_POSITION_RESET;
      end_track_r      <= csds_pkg::END_TRACK_RESET;
      out_valid_r      <= 1'b0;
    end else begin
      start_position_r <= start_position_nxt;
      end_track_r      <= end_track_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result beat is only pushed into a free output register.
  `CSDS_ASSERT_IMPL(a_push_into_free_slot, clk, rst_n, res_push, slot_free,
                    "result pushed over a waiting beat")
  // The last request of a batch closes the input until the batch is served.
  `CSDS_ASSERT(a_last_closes_input, clk, rst_n,
               (in_valid && in_ready && in_data.last_request) |=> !in_ready,
               "input still open after the last request")
  // Pushing the summary reopens the input for the next batch.
  `CSDS_ASSERT(a_summary_reopens_input, clk, rst_n,
               (res_push && res_data.is_summary) |=> in_ready,
               "input not reopened after the summary beat")

endmodule

### sim/cscan_disk_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscan_disk_scheduler_test
// Self-checking bench for the C-SCAN scheduler. Track requests are sent in
// batches under several head and end-track settings. A scoreboard in the
// bench sorts each batch, plans the upward sweep, the wrap and the low
// sweep, and compares every result beat field by field. The sender pauses
// in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module cscan_disk_scheduler_test;
  import csds_pkg::*;

  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned RANDOM_ITEMS = 480;

  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_BURSTY
  } rx_mode_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_START_POSITION;
  logic [FIELD_W-1:0]   cfg_data  = '0;

  cscan_disk_scheduler #(
    .MAX_PENDING(STORE_DEPTH),
    .TRACK_BITS (FIELD_W)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scoreboard copy of the registers and of the batch being loaded.
  logic [FIELD_W-1:0] head_start = START_POSITION_RESET;
  logic [FIELD_W-1:0] sweep_end  = END_TRACK_RESET;
  logic [FIELD_W-1:0] batch_track [STORE_DEPTH];
  int unsigned        batch_count   = 0;
  bit                 batch_dropped = 1'b0;

  // Result beats the sweep plan says are still to come, oldest first.
  out_item_t service_q [$];

  int unsigned errors        = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned batches_done  = 0;
  int unsigned batches_full  = 0;
  int unsigned reg_writes    = 0;
  int unsigned idle_cycles   = 0;

  // Sender burst shaping and receiver stall pattern.
  bit          tx_gaps       = 1'b0;
  int unsigned tx_burst_left = 0;
  rx_mode_t    rx_mode       = RX_OPEN;
  int unsigned rx_hold       = 0;

  // --------------------------------------------------------------------------
  // Sweep planner
  // --------------------------------------------------------------------------

  // Add a seek to the running total; pin at the top of the 18-bit range.
  function automatic logic [TOTAL_W-1:0] add_movement(input logic [TOTAL_W-1:0] acc,
                                                      input logic [TOTAL_W-1:0] amount);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, acc} + {1'b0, amount};
    return sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  endfunction

  function automatic out_item_t make_beat(input logic [FIELD_W-1:0] track,
                                          input logic [FIELD_W-1:0] seek,
                                          input logic [TOTAL_W-1:0] total,
                                          input logic               summary);
    out_item_t beat;
    beat.served_track   = track;
    beat.seek_distance  = seek;
    beat.total_movement = total;
    beat.is_summary     = summary;
    beat.overflow       = batch_dropped;
    beat.last_result    = summary;
    return beat;
  endfunction

  // Sort the loaded batch and queue the beats of one full C-SCAN pass.
  task automatic plan_cscan_sweep();
    logic [FIELD_W-1:0] sorted [STORE_DEPTH];
    logic [FIELD_W-1:0] v;
    logic [FIELD_W-1:0] head;
    logic [FIELD_W-1:0] first;
    logic [FIELD_W-1:0] seek;
    logic [TOTAL_W-1:0] total;
    int j;
    for (int i = 0; i < batch_count; i++) sorted[i] = batch_track[i];
    for (int i = 1; i < batch_count; i++) begin
      v = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    // A start above the end track is pulled down to it.
    first = (head_start > sweep_end) ? sweep_end : head_start;
    head  = first;
    total = '0;
    // Upward sweep: everything at or above the start.
    for (int i = 0; i < batch_count; i++) begin
      if (sorted[i] >= first) begin
        seek  = (sorted[i] >= head) ? sorted[i] - head : head - sorted[i];
        total = add_movement(total, seek);
        head  = sorted[i];
        service_q.push_back(make_beat(sorted[i], seek, total, 1'b0));
      end
    end
    // Wrap: run out to the end track, then fly back to track zero.
    total = add_movement(total, sweep_end - head);
    total = add_movement(total, sweep_end);
    head  = '0;
    // Low sweep: what lies below the start.
    for (int i = 0; i < batch_count; i++) begin
      if (sorted[i] < first) begin
        seek  = (sorted[i] >= head) ? sorted[i] - head : head - sorted[i];
        total = add_movement(total, seek);
        head  = sorted[i];
        service_q.push_back(make_beat(sorted[i], seek, total, 1'b0));
      end
    end
    service_q.push_back(make_beat('0, '0, total, 1'b1));
    batches_done++;
    if (batch_dropped) batches_full++;
    batch_count   = 0;
    batch_dropped = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------

  // Send one request beat; valid stays high on return for a back-to-back beat.
  task automatic send_request(input logic [FIELD_W-1:0] track, input logic last);
    logic [FIELD_W-1:0] kept;
    int unsigned gap;
    if (tx_burst_left == 0) begin
      if (tx_gaps) begin
        gap = $urandom_range(1, 8);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      tx_burst_left = $urandom_range(1, 12);
    end
    tx_burst_left--;
    @(negedge clk);
    in_valid              = 1'b1;
    in_data.request_track = track;
    in_data.last_request  = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    // Clamp to the end track; drop once the store is full.
    kept = (track > sweep_end) ? sweep_end : track;
    if (batch_count < STORE_DEPTH) begin
      batch_track[batch_count] = kept;
      batch_count++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (last) plan_cscan_sweep();
  endtask

  // Lower valid, then hold until every planned beat is back and the block
  // has had time to settle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (service_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_START_POSITION) head_start = value;
    else sweep_end = value;
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Reprogram both registers while the block is idle, in random order.
  task automatic set_geometry(input logic [FIELD_W-1:0] start, input logic [FIELD_W-1:0] last_trk);
    wait_drained();
    if ($urandom_range(0, 1)) begin
      write_reg(REG_START_POSITION, start);
      write_reg(REG_END_TRACK, last_trk);
    end else begin
      write_reg(REG_END_TRACK, last_trk);
      write_reg(REG_START_POSITION, start);
    end
  endtask

  // Mix of uniform tracks, in-range tracks, tracks near the start and end, and both field extremes.
  function automatic logic [FIELD_W-1:0] pick_track();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 65535);
      4, 5:       v = $urandom_range(0, sweep_end);
      6:          v = int'(head_start) + int'($urandom_range(0, 4)) - 2;
      7:          v = int'(sweep_end) + int'($urandom_range(0, 2)) - 1;
      8:          v = 0;
      default:    v = 65535;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[FIELD_W-1:0];
  endfunction

  // Mostly short batches, some longer ones up to a full store, a few that overrun it.
  function automatic int unsigned pick_batch_len();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return $urandom_range(1, 8);
    if (sel < 9) return $urandom_range(9, STORE_DEPTH);
    return $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8);
  endfunction

  task automatic run_random_batch(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_request(pick_track(), i == len - 1);
  endtask

  // --------------------------------------------------------------------------
  // Receiver stall pattern and result checker
  // --------------------------------------------------------------------------

  always @(negedge clk) begin
    case (rx_mode)
      RX_OPEN: begin
        out_ready = 1'b1;
      end
      RX_RANDOM: begin
        out_ready = ($urandom_range(0, 3) != 0);
      end
      default: begin
        // Short open windows followed by longer stalls.
        if (rx_hold == 0) begin
          out_ready = !out_ready;
          rx_hold   = out_ready ? $urandom_range(1, 6) : $urandom_range(1, 20);
        end else begin
          rx_hold--;
        end
      end
    endcase
  end

  task automatic check_field(input string name, input logic [TOTAL_W-1:0] want_v,
                             input logic [TOTAL_W-1:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (service_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: expected none, actual %h", $time, out_data);
      end else begin
        want = service_q.pop_front();
        check_field("served_track", want.served_track, out_data.served_track);
        check_field("seek_distance", want.seek_distance, out_data.seek_distance);
        check_field("total_movement", want.total_movement, out_data.total_movement);
        check_field("is_summary", want.is_summary, out_data.is_summary);
        check_field("overflow", want.overflow, out_data.overflow);
        check_field("last_result", want.last_result, out_data.last_result);
      end
    end
  end

  // Watchdog: end the run if no channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog: no beat for %0d cycles, %0d results outstanding",
               $time, idle_cycles, service_q.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset registers (start 0, end 200): tracks at zero, at the end, beyond
  // the end (clamped), the top of the field, and a duplicate.
  task automatic test_reset_geometry();
    tx_gaps = 1'b0;
    rx_mode = RX_OPEN;
    send_request(16'd0, 1'b0);
    send_request(16'd200, 1'b0);
    send_request(16'd201, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd100, 1'b0);
    send_request(16'd100, 1'b1);
  endtask

  // Start at track 150 on a full-range disk: requests just below, at and
  // above the start, so both sweeps and the wrap are exercised.
  task automatic test_high_start();
    set_geometry(16'd150, 16'hFFFF);
    tx_gaps = 1'b1;
    rx_mode = RX_RANDOM;
    send_request(16'hFFFF, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'd149, 1'b0);
    send_request(16'd150, 1'b0);
    send_request(16'd151, 1'b0);
    send_request(16'h8000, 1'b0);
    send_request(16'h7FFF, 1'b1);
  endtask

  // Start above an end track of 1: the start is pulled down to the end.
  task automatic test_start_beyond_end();
    set_geometry(16'hFFFF, 16'd1);
    rx_mode = RX_BURSTY;
    send_request(16'd0, 1'b0);
    send_request(16'd1, 1'b0);
    send_request(16'd2, 1'b0);
    send_request(16'hFFFF, 1'b1);
  endtask

  // One-request batches at both ends of the register range.
  task automatic test_single_requests();
    set_geometry(16'd0, 16'hFFFF);
    rx_mode = RX_OPEN;
    send_request(16'h5555, 1'b1);
    send_request(16'hAAAA, 1'b1);
    set_geometry(16'hFFFF, 16'hFFFF);
    send_request(16'hFFFF, 1'b1);
    send_request(16'd0, 1'b1);
  endtask

  // Exactly full store, one over, and a long overrun whose final request is
  // itself dropped but still closes the batch.
  task automatic test_store_full();
    set_geometry(16'($urandom_range(0, 65535)), 16'hFFFF);
    tx_gaps = 1'b1;
    rx_mode = RX_RANDOM;
    run_random_batch(STORE_DEPTH);
    run_random_batch(STORE_DEPTH + 1);
    run_random_batch(STORE_DEPTH + 8);
  endtask

  // Phases of random batches, each under its own geometry and idle pattern;
  // the first phases pin the register extremes.
  task automatic test_random_batches();
    int unsigned phase;
    int unsigned goal;
    int unsigned trk_end;
    int unsigned trk_start;
    phase = 0;
    goal  = items_sent + RANDOM_ITEMS - 3 * STORE_DEPTH - 9;
    while (items_sent < goal) begin
      case (phase)
        0: set_geometry(16'd0, 16'hFFFF);
        1: set_geometry(16'hFFFF, 16'hFFFF);
        2: set_geometry(16'd0, 16'd1);
        3: set_geometry(16'hFFFF, 16'd1);
        4: set_geometry(16'd1, 16'd1);
        5: set_geometry(START_POSITION_RESET, END_TRACK_RESET);
        default: begin
          trk_end   = $urandom_range(0, 1) ? $urandom_range(1, 300) : $urandom_range(1, 65535);
          trk_start = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, trk_end);
          set_geometry(trk_start[FIELD_W-1:0], trk_end[FIELD_W-1:0]);
        end
      endcase
      rx_mode = rx_mode_t'(phase % 3);
      tx_gaps = (phase % 4 != 1);
      // Batches go back to back; the next one loads once the last one's summary is pushed.
      for (int unsigned n = items_sent + 40; items_sent < n && items_sent < goal;)
        run_random_batch(pick_batch_len());
      phase++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_geometry();
    test_high_start();
    test_start_beyond_end();
    test_single_requests();
    test_store_full();
    test_random_batches();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests in %0d batches (%0d overran the store), %0d results,",
             items_sent, batches_done, batches_full, results_seen);
    $display("%0d register writes across start/end extremes; %0d errors", reg_writes, errors);
    if (errors == 0 && service_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
